>>> rtl/core/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
package spq_pkg;
   localparam int Depth   = 64;
   localparam int KeyBits = 32;
   localparam int IdxBits = $clog2(Depth);
   localparam int CntBits = $clog2(Depth + 1);

   localparam logic [1:0] KIND_ENQ = 2'd0;
   localparam logic [1:0] KIND_DEQ = 2'd1;
   localparam logic [1:0] KIND_CHG = 2'd2;
   localparam logic [1:0] KIND_CLR = 2'd3;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_EMPTY     = 3'd1;
   localparam logic [2:0] ST_NOT_FOUND = 3'd2;
   localparam logic [2:0] ST_NOT_LOWER = 3'd3;
   localparam logic [2:0] ST_FULL      = 3'd4;

   typedef struct packed {
      logic load;     // capture request
      logic insert;   // insert held entry
      logic remove;   // remove at held match (or head)
      logic rm_head;  // remove position is the head
      logic clear;
   } cmd_type;

   typedef struct packed {
      logic       found;
      logic       lower;
      logic       full;
      logic       empty;
      logic [1:0] kind;
   } stat_type;
endpackage

>>> rtl/core/spq_datapath.sv
// Shift-register cell array with parallel compare, insert and remove.
module spq_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  spq_pkg::cmd_type                cmd,
   output spq_pkg::stat_type               stat,
   input  logic [1:0]                      req_kind,
   input  logic [31:0]                     req_item_key,
   input  logic signed [15:0]              req_item_priority,
   output logic [spq_pkg::KeyBits-1:0]     head_key,
   output logic signed [15:0]              head_pri,
   output logic [spq_pkg::CntBits-1:0]     count
);
   localparam int D = spq_pkg::Depth;
   logic [spq_pkg::KeyBits-1:0] key_ff [D];
   logic signed [15:0]          pri_ff [D];
   logic [spq_pkg::CntBits-1:0] count_ff, count_in;
   logic [spq_pkg::KeyBits-1:0] hk_ff;
   logic signed [15:0]          hp_ff;
   logic [1:0]                  kind_ff;
   logic [D-1:0]                vld, match, first, after;
   logic [D-1:0]                rm_mask;

   // one-hot first match, and a mask of cells at or past it
   always_comb begin
      logic seen;
      seen = 1'b0;
      for (int i = 0; i < D; i++) begin
         vld[i]   = (spq_pkg::CntBits'(i) < count_ff);
         match[i] = vld[i] && (key_ff[i] == hk_ff);
         first[i] = match[i] && !seen;
         seen     = seen | match[i];
         rm_mask[i] = seen;
         // insertion goes before cell i when the new entry sorts below it
         after[i] = !vld[i] || (hp_ff < pri_ff[i]) ||
                    ((hp_ff == pri_ff[i]) && (hk_ff < key_ff[i]));
      end
   end

   always_comb begin
      logic lw;
      lw = 1'b0;
      for (int i = 0; i < D; i++)
         if (first[i] && (pri_ff[i] > hp_ff)) lw = 1'b1;
      stat.found = |match;
      stat.lower = lw;
      stat.full  = (count_ff == spq_pkg::CntBits'(D));
      stat.empty = (count_ff == '0);
      stat.kind  = kind_ff;
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.clear) count_in = '0;
      else if (cmd.remove) count_in = count_ff - 1'b1;
      else if (cmd.insert) count_in = count_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) count_ff <= '0;
      else       count_ff <= count_in;
      if (cmd.load) begin
         hk_ff   <= req_item_key[spq_pkg::KeyBits-1:0];
         hp_ff   <= req_item_priority;
         kind_ff <= req_kind;
      end
      for (int i = 0; i < D; i++) begin
         if (cmd.remove && (cmd.rm_head || rm_mask[i])) begin
            if (i + 1 < D) begin
               key_ff[i] <= key_ff[(i + 1) % D];
               pri_ff[i] <= pri_ff[(i + 1) % D];
            end
         end else if (cmd.insert && after[i]) begin
            if (i == 0 || after[(i + D - 1) % D] == 1'b0) begin
               key_ff[i] <= hk_ff;
               pri_ff[i] <= hp_ff;
            end else begin
               key_ff[i] <= key_ff[(i + D - 1) % D];
               pri_ff[i] <= pri_ff[(i + D - 1) % D];
            end
         end
      end
   end

   assign head_key = key_ff[0];
   assign head_pri = pri_ff[0];
   assign count    = count_ff;
endmodule

>>> rtl/core/spq_ctrl.sv
// Controller: sequences each transaction and builds the response.
module spq_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output spq_pkg::cmd_type                cmd,
   input  spq_pkg::stat_type               stat,
   input  logic [spq_pkg::KeyBits-1:0]     head_key,
   input  logic signed [15:0]              head_pri,
   input  logic [spq_pkg::CntBits-1:0]     count,
   output logic [31:0]                     rsp_out_key,
   output logic signed [15:0]              rsp_out_priority,
   output logic                            rsp_out_valid,
   output logic [2:0]                      rsp_status,
   output logic [6:0]                      rsp_occupancy
);
   typedef enum logic [3:0] {
      S_IDLE = 4'b0001, S_EXEC = 4'b0010, S_INS = 4'b0100, S_RSP = 4'b1000
   } state_type;
   state_type state_ff, state_in;
   logic [2:0] st_ff, st_in;
   logic       dv_ff, dv_in;
   logic [31:0] dk_ff, dk_in;
   logic signed [15:0] dp_ff, dp_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RSP);

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      st_in = st_ff; dv_in = dv_ff; dk_in = dk_ff; dp_in = dp_ff;
      unique case (state_ff)
         S_IDLE: if (req_valid) begin
            cmd.load = 1'b1;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            st_in = spq_pkg::ST_OK; dv_in = 1'b0;
            state_in = S_RSP;
            unique case (stat.kind)
               spq_pkg::KIND_ENQ: begin
                  if (stat.full) st_in = spq_pkg::ST_FULL;
                  else cmd.insert = 1'b1;
               end
               spq_pkg::KIND_DEQ: begin
                  if (stat.empty) st_in = spq_pkg::ST_EMPTY;
                  else begin
                     cmd.remove = 1'b1; cmd.rm_head = 1'b1;
                     dv_in = 1'b1;
                     dk_in = 32'(head_key); dp_in = head_pri;
                  end
               end
               spq_pkg::KIND_CHG: begin
                  if (!stat.found) st_in = spq_pkg::ST_NOT_FOUND;
                  else if (!stat.lower) st_in = spq_pkg::ST_NOT_LOWER;
                  else begin
                     cmd.remove = 1'b1;
                     state_in = S_INS;
                  end
               end
               default: cmd.clear = 1'b1;
            endcase
         end
         S_INS: begin
            cmd.insert = 1'b1;
            state_in = S_RSP;
         end
         S_RSP: if (rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
      st_ff <= st_in; dv_ff <= dv_in; dk_ff <= dk_in; dp_ff <= dp_in;
   end

   // head reported from the live array unless this was a dequeue
   always_comb begin
      logic deq, hv;
      deq = (stat.kind == spq_pkg::KIND_DEQ);
      hv  = (count != '0) && (stat.kind != spq_pkg::KIND_CLR);
      rsp_status    = st_ff;
      rsp_occupancy = 7'(count);
      if (deq) begin
         rsp_out_valid    = dv_ff;
         rsp_out_key      = dv_ff ? dk_ff : '0;
         rsp_out_priority = dv_ff ? dp_ff : '0;
      end else begin
         rsp_out_valid    = hv;
         rsp_out_key      = hv ? 32'(head_key) : '0;
         rsp_out_priority = hv ? head_pri : '0;
      end
   end
endmodule

>>> rtl/core/sorted_priority_queue.sv
// Sorted priority queue: cell array with parallel compare, plus controller.
// An accepted request goes through an execute state, then the response
// state; a change priority that moves an entry adds a reinsertion state.
// A new request is taken only after the previous response is accepted.
// Reset (synchronous, active high) empties the queue; entry contents are not
// cleared, only the occupancy count.
module sorted_priority_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_kind,
   input  logic [31:0]        req_item_key,
   input  logic signed [15:0] req_item_priority,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [31:0]        rsp_out_key,
   output logic signed [15:0] rsp_out_priority,
   output logic               rsp_out_valid,
   output logic [2:0]         rsp_status,
   output logic [6:0]         rsp_occupancy
);
   spq_pkg::cmd_type  cmd;
   spq_pkg::stat_type stat;
   logic [spq_pkg::KeyBits-1:0] head_key;
   logic signed [15:0]          head_pri;
   logic [spq_pkg::CntBits-1:0] count;

   // Datapath: holds the sorted cells and executes insert/remove commands.
   spq_datapath u_dp (
      .clock, .reset, .cmd, .stat, .req_kind, .req_item_key,
      .req_item_priority, .head_key, .head_pri, .count
   );

   // Controller: handshake and operation sequencing.
   spq_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .cmd, .stat, .head_key, .head_pri, .count, .rsp_out_key,
      .rsp_out_priority, .rsp_out_valid, .rsp_status, .rsp_occupancy
   );
endmodule

>>> tb/tb_sorted_priority_queue.sv
// Self-checking testbench for the sorted priority queue.
`timescale 1ns / 1ps

class spq_scoreboard;
   // Mirror of the queue contents, kept sorted by priority, then key.
   logic signed [15:0] pri_q[$];
   logic [31:0]        key_q[$];
   // Expected responses, oldest first.
   logic [31:0]        exp_key[$];
   logic signed [15:0] exp_pri[$];
   logic               exp_vld[$];
   logic [2:0]         exp_st[$];
   logic [6:0]         exp_occ[$];
   int                 errors;

   function void place(logic signed [15:0] p, logic [31:0] k);
      int pos;
      pos = 0;
      while (pos < pri_q.size() &&
             !(p < pri_q[pos] || (p == pri_q[pos] && k < key_q[pos])))
         pos++;
      pri_q.insert(pos, p);
      key_q.insert(pos, k);
   endfunction

   // Apply one accepted transaction to the mirror and queue its response.
   function void note_request(logic [1:0] kind, logic [31:0] k, logic signed [15:0] p);
      logic [2:0]         st;
      logic               vld;
      logic [31:0]        rk;
      logic signed [15:0] rp;
      bit                 head;
      int                 i;
      st = spq_pkg::ST_OK;
      vld = 0;
      rk = '0;
      rp = '0;
      head = 1;
      case (kind)
         spq_pkg::KIND_ENQ: begin
            if (pri_q.size() >= spq_pkg::Depth) st = spq_pkg::ST_FULL;
            else place(p, k);
         end
         spq_pkg::KIND_DEQ: begin
            head = 0;
            if (pri_q.size() == 0) st = spq_pkg::ST_EMPTY;
            else begin
               rk = key_q.pop_front();
               rp = pri_q.pop_front();
               vld = 1;
            end
         end
         spq_pkg::KIND_CHG: begin
            for (i = 0; i < key_q.size(); i++)
               if (key_q[i] == k) break;
            if (i >= key_q.size()) st = spq_pkg::ST_NOT_FOUND;
            else if (pri_q[i] <= p) st = spq_pkg::ST_NOT_LOWER;
            else begin
               pri_q.delete(i);
               key_q.delete(i);
               place(p, k);
            end
         end
         default: begin
            pri_q.delete();
            key_q.delete();
         end
      endcase
      if (head && pri_q.size() > 0) begin
         rk = key_q[0];
         rp = pri_q[0];
         vld = 1;
      end
      exp_key.push_back(rk);
      exp_pri.push_back(rp);
      exp_vld.push_back(vld);
      exp_st.push_back(st);
      exp_occ.push_back(7'(pri_q.size()));
   endfunction

   task report(string what);
      $display("mismatch: %s", what);
      errors++;
   endtask

   task check_response(logic [31:0] k, logic signed [15:0] p, logic v,
                       logic [2:0] st, logic [6:0] occ);
      if (exp_st.size() == 0) begin
         report("response with nothing outstanding");
         return;
      end
      if (k !== exp_key[0])
         report($sformatf("key %h, want %h", k, exp_key[0]));
      if (p !== exp_pri[0])
         report($sformatf("priority %0d, want %0d", p, exp_pri[0]));
      if (v !== exp_vld[0])
         report($sformatf("out_valid %b, want %b", v, exp_vld[0]));
      if (st !== exp_st[0])
         report($sformatf("status %0d, want %0d", st, exp_st[0]));
      if (occ !== exp_occ[0])
         report($sformatf("occupancy %0d, want %0d", occ, exp_occ[0]));
      void'(exp_key.pop_front());
      void'(exp_pri.pop_front());
      void'(exp_vld.pop_front());
      void'(exp_st.pop_front());
      void'(exp_occ.pop_front());
   endtask

   function int pending();
      return exp_st.size();
   endfunction
endclass

module tb_sorted_priority_queue;
   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_ready;
   logic [1:0]         req_kind = spq_pkg::KIND_CLR;
   logic [31:0]        req_item_key = '0;
   logic signed [15:0] req_item_priority = '0;
   logic               rsp_valid;
   logic               rsp_ready = 0;
   logic [31:0]        rsp_out_key;
   logic signed [15:0] rsp_out_priority;
   logic               rsp_out_valid;
   logic [2:0]         rsp_status;
   logic [6:0]         rsp_occupancy;

   spq_scoreboard board = new();
   logic [31:0]   recent_keys[$];   // keys likely present, used to hit change priority
   bit            rsp_random = 1;

   always #6 clock = ~clock;

   sorted_priority_queue u_dut (.*);

   // Mostly short gaps, now and then a long one.
   function int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Present one transaction, hold it until accepted, and note it.
   // Valid stays high afterwards; idle drops it when a gap follows.
   task send(logic [1:0] kind, logic [31:0] k, logic signed [15:0] p);
      req_valid <= 1;
      req_kind <= kind;
      req_item_key <= k;
      req_item_priority <= p;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_request(kind, k, p);
      if (kind == spq_pkg::KIND_ENQ) begin
         recent_keys.push_back(k);
         if (recent_keys.size() > 40) void'(recent_keys.pop_front());
      end
   endtask

   task idle(int n);
      if (n > 0) req_valid <= 0;
      repeat (n) @(posedge clock);
   endtask

   task send_gap(logic [1:0] kind, logic [31:0] k, logic signed [15:0] p);
      send(kind, k, p);
      idle(gap_len());
   endtask

   // Check a response at every accepted edge; throttle ready at random while rsp_random is set.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            board.check_response(rsp_out_key, rsp_out_priority, rsp_out_valid,
                                 rsp_status, rsp_occupancy);
         if (!rsp_random) rsp_ready <= 1;
         else begin
            int r;
            r = $urandom_range(0, 99);
            rsp_ready <= (r < 70) || (r >= 97);
         end
      end
   end

   // Draw a key: mostly from a small pool so matches and ties happen.
   function logic [31:0] pick_key();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40 && recent_keys.size() > 0)
         return recent_keys[$urandom_range(0, recent_keys.size() - 1)];
      if (r < 75) return $urandom_range(0, 15);
      return $urandom();
   endfunction

   function logic signed [15:0] pick_pri();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return $signed(16'($urandom_range(0, 8)) - 16'sd4);
      if (r < 60) return (r < 55) ? 16'sh8000 : 16'sh7FFF;
      return 16'($urandom());
   endfunction

   initial begin
      int n;
      int target;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: empty cases, extremes, ties, not-lower, not-found, full, clear.
      send(spq_pkg::KIND_DEQ, '0, '0);
      send(spq_pkg::KIND_CHG, 32'h5, 16'sh0);
      send(spq_pkg::KIND_ENQ, 32'hFFFF_FFFF, 16'sh7FFF);
      send(spq_pkg::KIND_ENQ, 32'h0, 16'sh8000);
      send(spq_pkg::KIND_ENQ, 32'h7, 16'sh0);
      send(spq_pkg::KIND_ENQ, 32'h7, 16'sh0);
      send(spq_pkg::KIND_ENQ, 32'h3, 16'sh0);
      send(spq_pkg::KIND_CHG, 32'h7, 16'sh0);
      send(spq_pkg::KIND_CHG, 32'h7, 16'sh1);
      send(spq_pkg::KIND_CHG, 32'hFFFF_FFFF, 16'sh8000);
      send(spq_pkg::KIND_CHG, 32'h1234, 16'sh0);
      send(spq_pkg::KIND_DEQ, '0, '0);
      send(spq_pkg::KIND_DEQ, '0, '0);
      send(spq_pkg::KIND_CLR, $urandom(), 16'($urandom()));
      send(spq_pkg::KIND_DEQ, '0, '0);
      rsp_random = 0;
      // Fill past capacity with the ready side held open, then drain some.
      for (n = 0; n < spq_pkg::Depth + 2; n++)
         send(spq_pkg::KIND_ENQ, $urandom(), 16'($urandom()));
      rsp_random = 1;
      send(spq_pkg::KIND_CHG, 32'hAAAA_5555, 16'sh8000);
      send(spq_pkg::KIND_DEQ, '0, '0);
      send(spq_pkg::KIND_CLR, '0, '0);

      // Random phase: bursts that grow then shrink, with occasional clears.
      target = 1400;
      for (n = 0; n < target; n++) begin
         int r;
         int bias;
         bias = ((n / 150) % 2 == 0) ? 55 : 25;
         r = $urandom_range(0, 99);
         if (r < bias) send_gap(spq_pkg::KIND_ENQ, pick_key(), pick_pri());
         else if (r < 70) send_gap(spq_pkg::KIND_DEQ, $urandom(), 16'($urandom()));
         else if (r < 98) send_gap(spq_pkg::KIND_CHG, pick_key(), pick_pri());
         else send_gap(spq_pkg::KIND_CLR, $urandom(), 16'($urandom()));
      end

      idle(1);
      while (board.pending() > 0) @(posedge clock);
      idle(10);
      if (board.errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      #20ms;
      $display("status: fail");
      $finish;
   end
endmodule
